FILE: rtl/core/anp_pkg.sv
// anp_pkg: types, character codes and helper functions of the ASCII number parser.
// Standalone package; used by the step logic and the top level.
package anp_pkg;

  // Number format register codes
  localparam logic [1:0] FMT_U32 = 2'd0;
  localparam logic [1:0] FMT_I32 = 2'd1;
  localparam logic [1:0] FMT_U8  = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_NUMBER_FORMAT = 1'b0;

  // Character codes
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_X_LOWER = 8'h78;
  localparam logic [7:0] CHAR_X_UPPER = 8'h58;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_A_UPPER = 8'h41;
  localparam logic [7:0] CHAR_F_UPPER = 8'h46;
  localparam logic [7:0] CHAR_A_LOWER = 8'h61;
  localparam logic [7:0] CHAR_F_LOWER = 8'h66;

  // Digit count limits per format
  localparam logic [3:0] I32_HEX_MAX = 4'd8;
  localparam logic [3:0] U8_HEX_MAX  = 4'd2;
  localparam logic [3:0] U8_DEC_MAX  = 4'd3;
  localparam logic [31:0] U8_MAX_VALUE = 32'd255;

  // Parser state carried between characters
  typedef struct packed {
    logic [3:0]  char_position;
    logic        hex_mode;
    logic        negative_sign;
    logic [31:0] accumulator;
    logic        error_seen;
    logic [3:0]  digit_count;
  } parser_state_t;

  // Result of one string
  typedef struct packed {
    logic [31:0] parsed_value;
    logic        parse_error;
  } parse_result_t;

  // Saturating 4-bit increment
  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    return (v == 4'hF) ? 4'hF : v + 4'd1;
  endfunction

  // Hex digit value; bit 4 set when the character is no hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h10;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO;
    end else if (c >= CHAR_A_UPPER && c <= CHAR_F_UPPER) begin
      d = c - CHAR_A_UPPER + 8'd10;
    end else if (c >= CHAR_A_LOWER && c <= CHAR_F_LOWER) begin
      d = c - CHAR_A_LOWER + 8'd10;
    end
    return d[4:0];
  endfunction

endpackage

FILE: rtl/core/anp_char_if.sv
// anp_char_if: request channel that carries one ASCII character.
// Standalone interface; no package dependency.
interface anp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

FILE: rtl/core/anp_result_if.sv
// anp_result_if: request channel that carries one parse result.
// Standalone interface; no package dependency.
interface anp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] parsed_value;
  logic        parse_error;

  modport source (output valid, output parsed_value, output parse_error, input ready);
  modport sink (input valid, input parsed_value, input parse_error, output ready);
endinterface

FILE: rtl/core/anp_step.sv
// anp_step: next parser state for one character and the final result at the terminator.
// Depends on anp_pkg.
module anp_step (
  input  anp_pkg::parser_state_t cur,
  input  logic [7:0]             char_code,
  input  logic [1:0]             number_format,
  output anp_pkg::parser_state_t nxt,
  output anp_pkg::parse_result_t result
);

  logic [4:0]  hex_val;
  logic [3:0]  dc_inc;
  logic [3:0]  prefix_pos;
  logic        is_x;
  logic [31:0] acc_dec;
  logic [31:0] acc_hex;

  assign hex_val    = anp_pkg::hex_digit(char_code);
  assign dc_inc     = anp_pkg::sat_inc(cur.digit_count);
  assign prefix_pos = {3'b000, cur.negative_sign} + 4'd1;
  assign is_x       = (char_code == anp_pkg::CHAR_X_LOWER) ||
                      (char_code == anp_pkg::CHAR_X_UPPER);
  // acc*10 + digit as shift-add
  assign acc_dec = {cur.accumulator[28:0], 3'b000} + {cur.accumulator[30:0], 1'b0}
                 + {24'd0, char_code - anp_pkg::CHAR_ZERO};
  assign acc_hex = {cur.accumulator[27:0], hex_val[3:0]};

  // Advance the parser by one character
  always_comb begin
    nxt = cur;
    if (!cur.error_seen) begin
      if (char_code == anp_pkg::CHAR_MINUS) begin
        if (number_format == anp_pkg::FMT_I32 && cur.char_position == 4'd0) begin
          nxt.negative_sign = 1'b1;
        end else begin
          nxt.error_seen = 1'b1;
        end
      end else if (is_x && !cur.hex_mode && cur.char_position == prefix_pos &&
                   cur.digit_count == 4'd1 && cur.accumulator == 32'd0) begin
        nxt.hex_mode    = 1'b1;
        nxt.digit_count = 4'd0;
        nxt.accumulator = 32'd0;
      end else if (cur.hex_mode) begin
        if (hex_val[4]) begin
          nxt.error_seen = 1'b1;
        end else begin
          nxt.digit_count = dc_inc;
          if ((number_format == anp_pkg::FMT_I32 && dc_inc > anp_pkg::I32_HEX_MAX) ||
              (number_format == anp_pkg::FMT_U8 && dc_inc > anp_pkg::U8_HEX_MAX)) begin
            nxt.error_seen = 1'b1;
          end else begin
            nxt.accumulator = acc_hex;
          end
        end
      end else begin
        if (!(char_code inside {[anp_pkg::CHAR_ZERO:anp_pkg::CHAR_NINE]})) begin
          nxt.error_seen = 1'b1;
        end else begin
          nxt.digit_count = dc_inc;
          if (number_format == anp_pkg::FMT_U8 && dc_inc > anp_pkg::U8_DEC_MAX) begin
            nxt.error_seen = 1'b1;
          end else begin
            nxt.accumulator = acc_dec;
          end
        end
      end
    end
    nxt.char_position = anp_pkg::sat_inc(cur.char_position);
  end

  // Range check, negation and width at the terminator
  always_comb begin
    result.parsed_value = cur.accumulator;
    result.parse_error  = cur.error_seen;
    case (number_format)
      anp_pkg::FMT_U8: begin
        if (cur.accumulator > anp_pkg::U8_MAX_VALUE) begin
          result.parse_error = 1'b1;
        end
        result.parsed_value = {24'd0, cur.accumulator[7:0]};
      end
      anp_pkg::FMT_I32: begin
        if (cur.negative_sign) begin
          result.parsed_value = 32'd0 - cur.accumulator;
        end
      end
      default: begin
        result.parsed_value = cur.accumulator;
      end
    endcase
    if (result.parse_error) begin
      result.parsed_value = 32'd0;
    end
  end

endmodule

FILE: rtl/core/ascii_number_parser_top.sv
// ascii_number_parser_top: ASCII decimal/hex string to integer parser.
// Depends on anp_pkg, anp_char_if, anp_result_if and anp_step.
//
// Usage:
//   chars   - sink channel, one ASCII character per request. A zero character
//             ends the string and yields exactly one request on results.
//   results - source channel with parsed_value and parse_error.
//   APB     - register number_format at byte address 0 (0 unsigned 32-bit,
//             1 signed 32-bit, 2 unsigned 8-bit); write it only while idle.
// Throughput: one character per cycle. Each character updates the parser
// state registers in the cycle it is accepted (one shift-add by 10 or 16).
// The result appears on results in the cycle after the terminator is
// accepted, from a single result register.
// Stall: while a result waits and results.ready is low, chars.ready drops;
// a character is still taken in the same cycle the waiting result leaves.
// Reset (rst, synchronous): parser state cleared, no result pending,
// number_format back to unsigned 32-bit.
module ascii_number_parser_top (
  input  logic               clk,
  input  logic               rst,
  anp_char_if.sink           chars,
  anp_result_if.source       results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0]             number_format;
  anp_pkg::parser_state_t state;
  anp_pkg::parser_state_t state_next;
  anp_pkg::parse_result_t step_result;
  anp_pkg::parse_result_t result;
  logic                   result_valid;
  logic                   char_take;
  logic                   is_term;
  logic                   cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == anp_pkg::REG_NUMBER_FORMAT);
  assign prdata    = (paddr[2] == anp_pkg::REG_NUMBER_FORMAT) ? {30'd0, number_format}
                                                              : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_format <= anp_pkg::FMT_U32;
    end else if (cfg_write) begin
      number_format <= pwdata[1:0];
    end
  end

  // Handshake
  assign chars.ready = !result_valid || results.ready;
  assign char_take   = chars.valid && chars.ready;
  assign is_term     = (chars.char_code == anp_pkg::CHAR_NUL);

  anp_step u_step (
    .cur           (state),
    .char_code     (chars.char_code),
    .number_format (number_format),
    .nxt           (state_next),
    .result        (step_result)
  );

  // Advance parser state; clear it after the terminator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (char_take) begin
      if (is_term) begin
        state <= '0;
      end else begin
        state <= state_next;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (char_take && is_term) begin
      result_valid <= 1'b1;
    end else if (results.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_take && is_term) begin
      result <= step_result;
    end
  end

  assign results.valid        = result_valid;
  assign results.parsed_value = result.parsed_value;
  assign results.parse_error  = result.parse_error;

  // Checks
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    char_take && is_term |=> state.char_position == 4'd0 && !state.error_seen &&
                             state.accumulator == 32'd0)
    else $error("parser state not cleared after terminator");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.parse_error |-> result.parsed_value == 32'd0)
    else $error("error result carries a nonzero value");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> result_valid && !results.ready)
    else $error("character input stalled without a waiting result");

  a_char_counts: assert property (@(posedge clk) disable iff (rst)
    char_take && !is_term |=> state.char_position != 4'd0)
    else $error("character position did not advance");

endmodule

FILE: tb/anp_parse_checker.sv
// anp_parse_checker: watches the character and result channels of the ASCII number parser,
// follows format writes on the APB port and compares every result with its own prediction.
// Depends on anp_pkg, anp_char_if and anp_result_if.
module anp_parse_checker (
  input  logic        clk,
  input  logic        rst,
  anp_char_if         chars,
  anp_result_if       results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned parses_pending,
  output int unsigned mismatch_count
);

  localparam logic [2:0] FORMAT_ADDR = {anp_pkg::REG_NUMBER_FORMAT, 2'b00};

  // Scan state of the string being received
  typedef struct packed {
    logic [3:0]  seen;
    logic        hex;
    logic        minus;
    logic [31:0] total;
    logic        bad;
    logic [3:0]  ndigits;
  } scan_t;

  scan_t                  scan;
  logic [1:0]             active_fmt;
  anp_pkg::parse_result_t expected_parses[$];
  int unsigned            errors = 0;

  function automatic logic [3:0] bump4(input logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

  // Fold one non-terminator character into the scan state
  function automatic scan_t absorb_char(input scan_t s, input logic [7:0] c,
                                        input logic [1:0] fmt);
    scan_t      n;
    logic [4:0] nib;
    logic [3:0] cnt;
    n = s;
    n.seen = bump4(s.seen);
    if (s.bad) return n;
    if (c == anp_pkg::CHAR_MINUS) begin
      if (fmt == anp_pkg::FMT_I32 && s.seen == 4'd0) n.minus = 1'b1;
      else n.bad = 1'b1;
      return n;
    end
    // A single leading zero followed by x switches to hex
    if ((c == anp_pkg::CHAR_X_LOWER || c == anp_pkg::CHAR_X_UPPER) && !s.hex &&
        s.seen == {3'b000, s.minus} + 4'd1 && s.ndigits == 4'd1 && s.total == 32'd0) begin
      n.hex = 1'b1;
      n.ndigits = 4'd0;
      n.total = 32'd0;
      return n;
    end
    if (s.hex) begin
      if (c >= anp_pkg::CHAR_ZERO && c <= anp_pkg::CHAR_NINE) begin
        nib = 5'(c - anp_pkg::CHAR_ZERO);
      end else if (c >= anp_pkg::CHAR_A_UPPER && c <= anp_pkg::CHAR_F_UPPER) begin
        nib = 5'(c - anp_pkg::CHAR_A_UPPER + 8'd10);
      end else if (c >= anp_pkg::CHAR_A_LOWER && c <= anp_pkg::CHAR_F_LOWER) begin
        nib = 5'(c - anp_pkg::CHAR_A_LOWER + 8'd10);
      end else begin
        nib = 5'h10;
      end
      if (nib[4]) begin
        n.bad = 1'b1;
        return n;
      end
      cnt = bump4(s.ndigits);
      n.ndigits = cnt;
      if ((fmt == anp_pkg::FMT_I32 && cnt > anp_pkg::I32_HEX_MAX) ||
          (fmt == anp_pkg::FMT_U8 && cnt > anp_pkg::U8_HEX_MAX)) begin
        n.bad = 1'b1;
        return n;
      end
      n.total = {s.total[27:0], nib[3:0]};
    end else begin
      if (c < anp_pkg::CHAR_ZERO || c > anp_pkg::CHAR_NINE) begin
        n.bad = 1'b1;
        return n;
      end
      cnt = bump4(s.ndigits);
      n.ndigits = cnt;
      if (fmt == anp_pkg::FMT_U8 && cnt > anp_pkg::U8_DEC_MAX) begin
        n.bad = 1'b1;
        return n;
      end
      n.total = s.total * 32'd10 + {24'd0, c - anp_pkg::CHAR_ZERO};
    end
    return n;
  endfunction

  // Apply range check, negation and width of the format at the terminator
  function automatic anp_pkg::parse_result_t close_string(input scan_t s,
                                                          input logic [1:0] fmt);
    anp_pkg::parse_result_t r;
    r.parsed_value = s.total;
    r.parse_error = s.bad;
    if (fmt == anp_pkg::FMT_U8) begin
      if (s.total > anp_pkg::U8_MAX_VALUE) r.parse_error = 1'b1;
      r.parsed_value = s.total & 32'hFF;
    end else if (fmt == anp_pkg::FMT_I32 && s.minus) begin
      r.parsed_value = 32'd0 - s.total;
    end
    if (r.parse_error) r.parsed_value = 32'd0;
    return r;
  endfunction

  // Track requests on both channels and the format register
  always @(posedge clk) begin
    anp_pkg::parse_result_t want;
    if (rst) begin
      scan = '0;
      active_fmt = anp_pkg::FMT_U32;
      expected_parses.delete();
    end else begin
      // Compare a leaving result with the oldest prediction
      if (results.valid && results.ready) begin
        if (expected_parses.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %h error %b", $time,
                   results.parsed_value, results.parse_error);
        end else begin
          want = expected_parses.pop_front();
          if (results.parsed_value !== want.parsed_value) begin
            errors++;
            $display("%0t: parsed_value expected %h actual %h", $time,
                     want.parsed_value, results.parsed_value);
          end
          if (results.parse_error !== want.parse_error) begin
            errors++;
            $display("%0t: parse_error expected %b actual %b", $time,
                     want.parse_error, results.parse_error);
          end
        end
      end
      // Advance the scan, or predict a result on the terminator
      if (chars.valid && chars.ready) begin
        if (chars.char_code != anp_pkg::CHAR_NUL) begin
          scan = absorb_char(scan, chars.char_code, active_fmt);
        end else begin
          expected_parses.push_back(close_string(scan, active_fmt));
          scan = '0;
        end
      end
      if (psel && penable && pwrite && pready && paddr == FORMAT_ADDR) begin
        active_fmt = pwdata[1:0];
      end
    end
    parses_pending <= expected_parses.size();
    mismatch_count <= errors;
  end

endmodule

FILE: tb/ascii_number_parser_top_tb.sv
// ascii_number_parser_top_tb: drives strings and format writes into the ASCII number parser
// with random gaps and stalls; anp_parse_checker does the prediction and comparison.
// Depends on anp_pkg, anp_char_if, anp_result_if, anp_parse_checker and the parser RTL.
module ascii_number_parser_top_tb;

  localparam logic [2:0] FORMAT_ADDR = {anp_pkg::REG_NUMBER_FORMAT, 2'b00};
  localparam logic [1:0] FMT_SPARE   = 2'd3;
  localparam int         CHAR_TARGET = 1950;
  localparam int         PHASE_CHARS = 120;
  localparam int         HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned parses_pending;
  int unsigned mismatch_count;
  int          sent = 0;
  bit          steady = 1'b0;
  bit          hold_results = 1'b0;
  logic [7:0]  line_q[$];

  anp_char_if   chars ();
  anp_result_if results ();

  ascii_number_parser_top dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  anp_parse_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .chars          (chars),
    .results        (results),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .parses_pending (parses_pending),
    .mismatch_count (mismatch_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Offer one character after a random gap and hold it until accepted
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars.valid <= 1'b1;
    chars.char_code <= c;
    do @(posedge clk); while (!chars.ready);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid and wait until every predicted result has left, plus a short drain
  task automatic wait_idle();
    chars.valid <= 1'b0;
    @(posedge clk);
    while (parses_pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write of the format register: setup cycle, then access cycle
  task automatic write_format(input logic [1:0] fmt);
    logic [31:0] noise;
    noise = $urandom();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FORMAT_ADDR;
    pwdata <= {noise[31:2], fmt};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Build one random string: mostly well-formed numbers, some broken, some noise
  task automatic build_line(input logic [1:0] fmt);
    int kind;
    int len;
    int pick;
    line_q.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      if ((fmt == anp_pkg::FMT_I32 && $urandom_range(0, 1) == 1) ||
          $urandom_range(0, 19) == 0) begin
        line_q.push_back(anp_pkg::CHAR_MINUS);
      end
      if ($urandom_range(0, 1) == 1) begin
        line_q.push_back(anp_pkg::CHAR_ZERO);
        line_q.push_back($urandom_range(0, 1) ? anp_pkg::CHAR_X_LOWER
                                              : anp_pkg::CHAR_X_UPPER);
        len = (fmt == anp_pkg::FMT_U8) ? $urandom_range(0, 3) : $urandom_range(0, 10);
        repeat (len) begin
          pick = $urandom_range(0, 21);
          if (pick < 10) line_q.push_back(anp_pkg::CHAR_ZERO + 8'(pick));
          else if (pick < 16) line_q.push_back(anp_pkg::CHAR_A_UPPER + 8'(pick - 10));
          else line_q.push_back(anp_pkg::CHAR_A_LOWER + 8'(pick - 16));
        end
      end else begin
        if (fmt == anp_pkg::FMT_U8) len = $urandom_range(1, 4);
        else len = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 11);
        repeat (len) line_q.push_back(anp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      // Corrupt one character now and then
      if (kind == 6) line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(1, 255));
    end else if (kind <= 8) begin
      len = $urandom_range(1, 6);
      repeat (len) line_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // Result side: random stall per request, one long hold-off on demand
  initial begin
    int stall;
    results.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
    end
  end

  // Character side and verdict
  initial begin
    int         phase;
    int         phase_end;
    logic [1:0] fmt;
    chars.valid <= 1'b0;
    chars.char_code <= anp_pkg::CHAR_NUL;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= FORMAT_ADDR;
    pwdata <= 32'd0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Unsigned 32-bit after reset: empty string, mixed-case hex, stray minus
    send_char(anp_pkg::CHAR_NUL);
    send_text("0xfF");
    send_char(anp_pkg::CHAR_NUL);
    send_text("-");
    send_char(anp_pkg::CHAR_NUL);
    // Signed: lone minus, prefix without digits, minus after a digit
    wait_idle();
    write_format(anp_pkg::FMT_I32);
    send_text("-");
    send_char(anp_pkg::CHAR_NUL);
    send_text("-0X");
    send_char(anp_pkg::CHAR_NUL);
    send_text("1-");
    send_char(anp_pkg::CHAR_NUL);
    // Unsigned 8-bit range edge
    wait_idle();
    write_format(anp_pkg::FMT_U8);
    send_text("255");
    send_char(anp_pkg::CHAR_NUL);
    send_text("256");
    send_char(anp_pkg::CHAR_NUL);
    // Spare format code acts as unsigned 32-bit
    wait_idle();
    write_format(FMT_SPARE);
    send_text("9");
    send_char(anp_pkg::CHAR_NUL);
    // Switch to 8-bit in the middle of a string
    wait_idle();
    write_format(anp_pkg::FMT_U32);
    send_text("12");
    wait_idle();
    write_format(anp_pkg::FMT_U8);
    send_text("34");
    send_char(anp_pkg::CHAR_NUL);

    // Random phases, each under one format setting
    phase = 0;
    while (sent < CHAR_TARGET) begin
      wait_idle();
      case (phase)
        0: fmt = anp_pkg::FMT_I32;
        1: fmt = anp_pkg::FMT_U8;
        2: fmt = FMT_SPARE;
        3: fmt = anp_pkg::FMT_U32;
        default: fmt = 2'($urandom_range(0, 3));
      endcase
      write_format(fmt);
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 5) hold_results = 1'b1;
      phase_end = sent + PHASE_CHARS;
      while (sent < phase_end) begin
        build_line(fmt);
        foreach (line_q[i]) send_char(line_q[i]);
        send_char(anp_pkg::CHAR_NUL);
      end
      phase++;
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/anp_pkg.sv
rtl/core/anp_char_if.sv
rtl/core/anp_result_if.sv
rtl/core/anp_step.sv
rtl/core/ascii_number_parser_top.sv
tb/anp_parse_checker.sv
tb/ascii_number_parser_top_tb.sv
